// ===== rtl/dfd_pkg.sv =====
`default_nettype none
package dfd_pkg;
   localparam int TableDepth = 1024;
   localparam int AddrW = $clog2(TableDepth);
   localparam int CountW = $clog2(TableDepth + 1);
   localparam int EntryW = 64 + 64 + 32;

   localparam logic [63:0] OffsetA = 64'hcbf29ce484222325;
   localparam logic [63:0] OffsetB = 64'd7809847782465536322;
   localparam logic [63:0] PrimeA = 64'd1099511628211;
   localparam logic [63:0] PrimeB = 64'd14029467366897019727;
   localparam logic [31:0] LenMax = 32'hFFFF_FFFF;

   localparam logic [2:0] CmdContent = 3'd0;
   localparam logic [2:0] CmdCaption = 3'd1;
   localparam logic [2:0] CmdEnd = 3'd2;
   localparam logic [2:0] CmdOutcome = 3'd3;
   localparam logic [2:0] CmdClear = 3'd4;

   typedef struct packed {
      logic load_byte;
      logic count_len;
      logic mul_step;
      logic mix_done;
      logic restart;
      logic capture_pending;
      logic clear_pending;
      logic search_start;
      logic search_step;
      logic commit;
      logic clear_ring;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_last;
      logic search_done;
      logic match;
      logic pending_valid;
      logic [CountW-1:0] entry_count;
   } dp_status_type;
endpackage
`default_nettype wire

// ===== rtl/dual_fnv_dedup_filter_top.sv =====
// Byte commands: four 64x16 partial-product steps of the multiply, then a mix step.
// End of message: with dedup enabled, searches N stored entries, one RAM read per cycle.
// Delivery outcome passes through a commit state; clear and unused codes finish in idle. One item at a time.
// Result registered; input stalls while a result waits under rsp_stall.
// Synchronous active-high reset: hashes to offsets, ring empty, no pending entry.
`default_nettype none
module dual_fnv_dedup_filter_top
   import dfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_command,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_delivered,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_reply_kind,
   output logic             rsp_is_duplicate,
   output logic             rsp_delivery_ok,
   output logic [10:0]      rsp_stored_entries,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_dedup_enable
);
   logic dedup_enable_ff;
   dp_cmd_type cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         dedup_enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         dedup_enable_ff <= csr_dedup_enable;
      end
   end

   dfd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_delivered,
      .dedup_enable(dedup_enable_ff), .rsp_valid, .rsp_stall, .rsp_reply_kind,
      .rsp_is_duplicate, .rsp_delivery_ok, .rsp_stored_entries,
      .cmd, .status
   );

   dfd_datapath u_dp (
      .clock, .reset, .byte_in(req_data_byte), .cmd, .status
   );

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      status.entry_count <= CountW'(TableDepth)) else $error("count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_ring |=> status.entry_count == '0) else $error("clear failed");
`endif
endmodule
`default_nettype wire

// ===== rtl/dfd_ram.sv =====
`default_nettype none
module dfd_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/dfd_datapath.sv =====
`default_nettype none
module dfd_datapath
   import dfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [7:0]    byte_in,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      status
);
   // 64x64 constant multiply as four 64x16 partial products, one per cycle
   logic [63:0] hash_a_ff, hash_b_ff, acc_a_ff, acc_b_ff;
   logic [63:0] op_a_ff, op_b_ff;
   logic [1:0]  part_ff;
   logic [31:0] len_ff;
   logic        pend_v_ff;
   logic [63:0] pend_a_ff, pend_b_ff;
   logic [31:0] pend_l_ff;
   logic [CountW-1:0] count_ff;
   logic [AddrW-1:0]  slot_ff;
   logic [CountW-1:0] idx_ff;
   logic              rd_v_ff, match_ff, done_ff;
   logic [EntryW-1:0] rd_data;
   logic [15:0] pa_seg, pb_seg;
   logic [63:0] prod_a, prod_b;
   logic [AddrW-1:0] rd_addr;
   logic        wr_en;

   always_comb begin
      pa_seg = PrimeA[16*part_ff +: 16];
      pb_seg = PrimeB[16*part_ff +: 16];
      prod_a = (op_a_ff * {48'd0, pa_seg}) << (16 * part_ff);
      prod_b = (op_b_ff * {48'd0, pb_seg}) << (16 * part_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         op_a_ff <= hash_a_ff ^ {56'd0, byte_in};
         op_b_ff <= hash_b_ff ^ {56'd0, byte_in};
         acc_a_ff <= '0;
         acc_b_ff <= '0;
      end else if (cmd.mul_step) begin
         acc_a_ff <= acc_a_ff + prod_a;
         acc_b_ff <= acc_b_ff + prod_b;
      end
      if (cmd.capture_pending) begin
         pend_a_ff <= hash_a_ff;
         pend_b_ff <= hash_b_ff;
         pend_l_ff <= len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_a_ff <= OffsetA;
         hash_b_ff <= OffsetB;
         len_ff <= '0;
         part_ff <= '0;
         pend_v_ff <= 1'b0;
         count_ff <= '0;
         slot_ff <= '0;
         idx_ff <= '0;
         rd_v_ff <= 1'b0;
         match_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (cmd.load_byte) begin
            part_ff <= '0;
         end else if (cmd.mul_step) begin
            part_ff <= part_ff + 2'd1;
         end
         if (cmd.mix_done) begin
            hash_a_ff <= acc_a_ff;
            hash_b_ff <= acc_b_ff;
         end
         if (cmd.count_len && len_ff != LenMax) begin
            len_ff <= len_ff + 32'd1;
         end
         if (cmd.restart) begin
            hash_a_ff <= OffsetA;
            hash_b_ff <= OffsetB;
            len_ff <= '0;
         end
         if (cmd.capture_pending) begin
            pend_v_ff <= 1'b1;
         end else if (cmd.clear_pending) begin
            pend_v_ff <= 1'b0;
         end
         if (cmd.commit && pend_v_ff) begin
            slot_ff <= (slot_ff == AddrW'(TableDepth - 1)) ? '0 : slot_ff + 1'b1;
            if (count_ff != CountW'(TableDepth)) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         if (cmd.clear_ring) begin
            count_ff <= '0;
            slot_ff <= '0;
         end
         if (cmd.search_start) begin
            idx_ff <= '0;
            rd_v_ff <= 1'b0;
            match_ff <= 1'b0;
            done_ff <= (count_ff == '0);
         end else if (cmd.search_step && !done_ff) begin
            if (rd_v_ff && rd_data == {hash_a_ff, hash_b_ff, len_ff}) begin
               match_ff <= 1'b1;
               done_ff <= 1'b1;
            end else if (idx_ff == count_ff) begin
               done_ff <= 1'b1;
            end
            if (idx_ff != count_ff) begin
               idx_ff <= idx_ff + 1'b1;
               rd_v_ff <= 1'b1;
            end else begin
               rd_v_ff <= 1'b0;
            end
         end
      end
   end

   assign rd_addr = idx_ff[AddrW-1:0];
   assign wr_en = cmd.commit && pend_v_ff;

   dfd_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data ({pend_a_ff, pend_b_ff, pend_l_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.mul_last = (part_ff == 2'd3);
   assign status.search_done = done_ff;
   assign status.match = match_ff;
   assign status.pending_valid = pend_v_ff;
   assign status.entry_count = count_ff;
endmodule
`default_nettype wire

// ===== rtl/dfd_ctrl.sv =====
`default_nettype none
module dfd_ctrl
   import dfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [2:0]    req_command,
   input  wire logic          req_delivered,
   input  wire logic          dedup_enable,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic               rsp_reply_kind,
   output logic               rsp_is_duplicate,
   output logic               rsp_delivery_ok,
   output logic [10:0]        rsp_stored_entries,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StMul = 3'd1;
   localparam logic [2:0] StMix = 3'd2;
   localparam logic [2:0] StSearch = 3'd3;
   localparam logic [2:0] StFinish = 3'd4;
   localparam logic [2:0] StCommit = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       content_ff, content_in;
   logic       deliv_ff, deliv_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       kind_ff, kind_in, dup_ff, dup_in, ok_ff, ok_in;
   logic [10:0] cnt_ff, cnt_in;
   logic       accept;

   assign req_stall = (state_ff != StIdle) || (rsp_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      content_in = content_ff;
      deliv_in = deliv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in = kind_ff;
      dup_in = dup_ff;
      ok_in = ok_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               unique case (req_command) inside
                  CmdContent, CmdCaption: begin
                     cmd.load_byte = 1'b1;
                     content_in = (req_command == CmdContent);
                     state_in = StMul;
                  end
                  CmdEnd: begin
                     if (dedup_enable) begin
                        cmd.search_start = 1'b1;
                        state_in = StSearch;
                     end else begin
                        cmd.clear_pending = 1'b1;
                        cmd.restart = 1'b1;
                        rsp_valid_in = 1'b1;
                        kind_in = 1'b0;
                        dup_in = 1'b0;
                        ok_in = 1'b0;
                        cnt_in = 11'(status.entry_count);
                     end
                  end
                  CmdOutcome: begin
                     deliv_in = req_delivered;
                     state_in = StCommit;
                  end
                  CmdClear: cmd.clear_ring = 1'b1;
                  default: ;
               endcase
            end
         end
         StMul: begin
            cmd.mul_step = 1'b1;
            if (status.mul_last) begin
               state_in = StMix;
            end
         end
         StMix: begin
            cmd.mix_done = 1'b1;
            cmd.count_len = content_ff;
            state_in = StIdle;
         end
         StSearch: begin
            cmd.search_step = 1'b1;
            if (status.search_done) begin
               state_in = StFinish;
            end
         end
         StFinish: begin
            if (status.match) begin
               cmd.clear_pending = 1'b1;
            end else begin
               cmd.capture_pending = 1'b1;
            end
            cmd.restart = 1'b1;
            rsp_valid_in = 1'b1;
            kind_in = 1'b0;
            dup_in = status.match;
            ok_in = 1'b0;
            cnt_in = 11'(status.entry_count);
            state_in = StIdle;
         end
         StCommit: begin
            if (deliv_ff) begin
               cmd.commit = 1'b1;
            end
            cmd.clear_pending = 1'b1;
            rsp_valid_in = 1'b1;
            kind_in = 1'b1;
            dup_in = 1'b0;
            ok_in = deliv_ff;
            cnt_in = 11'(status.entry_count)
               + 11'(deliv_ff && status.pending_valid
                     && status.entry_count != CountW'(TableDepth));
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      content_ff <= content_in;
      deliv_ff <= deliv_in;
      kind_ff <= kind_in;
      dup_ff <= dup_in;
      ok_ff <= ok_in;
      cnt_ff <= cnt_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_reply_kind = kind_ff;
   assign rsp_is_duplicate = dup_ff;
   assign rsp_delivery_ok = ok_ff;
   assign rsp_stored_entries = cnt_ff;
endmodule
`default_nettype wire
